>>> rtl/core/tcce_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the text console cursor engine.
// No dependencies; every other file of the block imports this package.
package tcce_pkg;

    // Screen geometry and tab spacing.
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_STOP  = 8;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    // Field widths of the request and result channels.
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 2 * COLOR_W;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the func field.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST_DRAW = 8'h7F;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Sized forms of the geometry for datapath use.
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] TAB_STEP  = COL_W'(TAB_STOP);
    localparam logic [COL_W-1:0] TAB_MASK  = COL_W'(TAB_STOP - 1);
    localparam logic [LOC_W-1:0] CELL_LAST = LOC_W'(CELLS - 1);
    localparam logic [LOC_W-1:0] SCROLL_END = LOC_W'(SCROLL_CELLS);

    // Classified command carried from the front to the back.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_DRAW,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_CLEAR,
        CMD_SETCUR
    } t_cmd;

    typedef struct packed {
        t_cmd               kind;
        logic [CHAR_W-1:0]  ch;
        logic [ATTR_W-1:0]  attr;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } t_cmd_entry;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCROLL,
        BK_CLEAR
    } t_bk_state;

    // Linear cell index of a row and column.
    function automatic logic [LOC_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [LOC_W-1:0] base;
        base = LOC_W'(row) * LOC_W'(COLUMNS);
        return base + LOC_W'(col);
    endfunction

endpackage

>>> rtl/core/tcce_front.sv
`timescale 1ns / 1ps
// Front end of the console engine: takes requests and sorts them into commands.
// Depends on tcce_pkg; feeds tcce_queue.
module tcce_front (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcce_pkg::FUNC_W-1:0]   i_func,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_back_color,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_fore_color,
    input  logic [tcce_pkg::COL_W-1:0]    i_new_col,
    input  logic [tcce_pkg::ROW_W-1:0]    i_new_row,
    input  logic                          i_q_full,
    input  logic                          i_init_busy,
    output logic                          o_push,
    output tcce_pkg::t_cmd_entry          o_entry
);
    import tcce_pkg::*;

    t_cmd put_kind;

    // Hold off requests while the queue is full or the screen is still being cleared.
    assign o_in_stall = i_q_full || i_init_busy;
    assign o_push     = i_in_valid && !o_in_stall;

    // Sort a character code into the action it asks for.
    always_comb begin
        unique case (i_char_code) inside
            CH_BS:                    put_kind = CMD_BS;
            CH_TAB:                   put_kind = CMD_TAB;
            CH_CR:                    put_kind = CMD_CR;
            CH_LF:                    put_kind = CMD_LF;
            [CH_SPACE:CH_LAST_DRAW]:  put_kind = CMD_DRAW;
            default:                  put_kind = CMD_NOP;
        endcase
    end

    // Build the queue entry; cursor targets are clamped to the screen here.
    always_comb begin
        o_entry.ch   = i_char_code;
        o_entry.attr = {i_back_color, i_fore_color};
        o_entry.col  = (i_new_col < COL_LIMIT) ? i_new_col : COL_LAST;
        o_entry.row  = (i_new_row < ROW_LIMIT) ? i_new_row : ROW_LAST;
        unique case (i_func)
            FUNC_PUT:   o_entry.kind = put_kind;
            FUNC_CLEAR: o_entry.kind = CMD_CLEAR;
            FUNC_SET:   o_entry.kind = CMD_SETCUR;
            default:    o_entry.kind = CMD_NOP;
        endcase
    end

endmodule

>>> rtl/core/tcce_queue.sv
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the back end.
// Depends on tcce_pkg for the entry type and depth.
module tcce_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tcce_pkg::t_cmd_entry  i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output tcce_pkg::t_cmd_entry  o_entry
);
    import tcce_pkg::*;

    t_cmd_entry          r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> rtl/core/tcce_back.sv
`timescale 1ns / 1ps
// Back end of the console engine: cursor, screen store, scroll and clear passes,
// and the result register. Depends on tcce_pkg; fed by tcce_queue.
module tcce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tcce_pkg::t_cmd_entry          i_q_entry,
    output logic                          o_q_pop,
    output logic                          o_init_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcce_pkg::LOC_W-1:0]    o_cursor_location,
    output logic [tcce_pkg::COL_W-1:0]    o_old_col,
    output logic [tcce_pkg::ROW_W-1:0]    o_old_row,
    output logic                          o_cell_written,
    output logic [tcce_pkg::LOC_W-1:0]    o_cell_address,
    output logic [tcce_pkg::CELL_W-1:0]   o_cell_value,
    output logic                          o_scrolled
);
    import tcce_pkg::*;

    // Sequencer and cursor.
    t_bk_state          r_state;
    t_bk_state          n_state;
    logic [LOC_W-1:0]   r_ptr;
    logic [LOC_W-1:0]   n_ptr;
    logic               r_init;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    // Screen store with one write and one registered read port.
    logic [CELL_W-1:0]  r_cells [CELLS];
    logic [CELL_W-1:0]  r_rdata;
    logic               r_wv;
    logic [LOC_W-1:0]   r_wdst;
    logic               r_wblank;
    logic               rd_en;
    logic [LOC_W-1:0]   rd_addr;
    logic               mem_we;
    logic [LOC_W-1:0]   mem_wa;
    logic [CELL_W-1:0]  mem_wd;

    // Result register.
    logic               r_o_valid;
    logic [LOC_W-1:0]   r_o_loc;
    logic [COL_W-1:0]   r_o_old_col;
    logic [ROW_W-1:0]   r_o_old_row;
    logic               r_o_wr;
    logic [LOC_W-1:0]   r_o_addr;
    logic [CELL_W-1:0]  r_o_val;
    logic               r_o_scroll;

    // Command execution.
    logic               out_free;
    logic               start;
    logic [LOC_W-1:0]   here;
    logic [COL_W-1:0]   ex_col;
    logic [ROW_W-1:0]   ex_row;
    logic               ex_wr;
    logic [LOC_W-1:0]   ex_addr;
    logic [CELL_W-1:0]  ex_val;
    logic [COL_W-1:0]   ex_old_col;
    logic [ROW_W-1:0]   ex_old_row;
    logic               ex_scroll;
    logic [LOC_W-1:0]   ex_loc;

    assign out_free = !r_o_valid || !i_out_stall;
    assign start    = (r_state == BK_IDLE) && i_q_valid && !r_wv && out_free;
    assign here     = cell_index(r_row, r_col);

    // Carry out one command on the cursor and work out its result.
    always_comb begin
        ex_col     = r_col;
        ex_row     = r_row;
        ex_wr      = 1'b0;
        ex_addr    = '0;
        ex_val     = '0;
        ex_old_col = '0;
        ex_old_row = '0;
        ex_scroll  = 1'b0;
        unique case (i_q_entry.kind)
            CMD_DRAW: begin
                ex_wr   = 1'b1;
                ex_addr = here;
                ex_val  = {i_q_entry.attr, i_q_entry.ch};
                ex_col  = r_col + 1'b1;
            end
            CMD_BS: begin
                if (r_col != '0) begin
                    ex_col  = r_col - 1'b1;
                    ex_wr   = 1'b1;
                    ex_addr = here - 1'b1;
                    ex_val  = {i_q_entry.attr, CH_SPACE};
                end
            end
            CMD_TAB: begin
                ex_col = r_col + TAB_STEP - (r_col & TAB_MASK);
            end
            CMD_CR: begin
                ex_col = '0;
            end
            CMD_LF: begin
                ex_col = '0;
                ex_row = r_row + 1'b1;
            end
            CMD_CLEAR: begin
                ex_col = '0;
                ex_row = '0;
            end
            CMD_SETCUR: begin
                ex_old_col = r_col;
                ex_old_row = r_row;
                ex_col     = i_q_entry.col;
                ex_row     = i_q_entry.row;
            end
            default: begin
            end
        endcase
        // Wrap past the last column, then scroll past the last row.
        if (ex_col >= COL_LIMIT) begin
            ex_col = '0;
            ex_row = ex_row + 1'b1;
        end
        if (ex_row >= ROW_LIMIT) begin
            ex_row    = ROW_LAST;
            ex_scroll = 1'b1;
        end
        ex_loc = cell_index(ex_row, ex_col);
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (start && ex_scroll) begin
                    n_state = BK_SCROLL;
                end else if (start && i_q_entry.kind == CMD_CLEAR) begin
                    n_state = BK_CLEAR;
                end
            end
            BK_SCROLL, BK_CLEAR: begin
                if (r_ptr == CELL_LAST) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs: pass pointer, store read and write port.
    always_comb begin
        n_ptr   = (r_state == BK_IDLE) ? '0 : r_ptr + 1'b1;
        rd_addr = r_ptr + LOC_W'(COLUMNS);
        rd_en   = (r_state == BK_SCROLL) && (r_ptr < SCROLL_END);
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = BLANK_CELL;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
            end
            default: begin
                if (r_wv) begin
                    mem_we = 1'b1;
                    mem_wa = r_wdst;
                    mem_wd = r_wblank ? BLANK_CELL : r_rdata;
                end else if (start && ex_wr) begin
                    mem_we = 1'b1;
                    mem_wa = ex_addr;
                    mem_wd = ex_val;
                end
            end
        endcase
    end

    assign o_q_pop     = start;
    assign o_init_busy = r_init;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_ptr     <= '0;
            r_init    <= 1'b1;
            r_col     <= '0;
            r_row     <= '0;
            r_wv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_wv    <= (r_state == BK_SCROLL);
            if (r_state == BK_CLEAR && r_ptr == CELL_LAST) begin
                r_init <= 1'b0;
            end
            if (start) begin
                r_col     <= ex_col;
                r_row     <= ex_row;
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Scroll copy pipeline: the cell read now is written one row up next cycle.
    always_ff @(posedge i_clk) begin
        r_wdst   <= r_ptr;
        r_wblank <= (r_ptr >= SCROLL_END);
        if (rd_en) begin
            r_rdata <= r_cells[rd_addr];
        end
    end

    // Screen store write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_wa] <= mem_wd;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_o_loc     <= ex_loc;
            r_o_old_col <= ex_old_col;
            r_o_old_row <= ex_old_row;
            r_o_wr      <= ex_wr;
            r_o_addr    <= ex_addr;
            r_o_val     <= ex_val;
            r_o_scroll  <= ex_scroll;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_cursor_location = r_o_loc;
    assign o_old_col         = r_o_old_col;
    assign o_old_row         = r_o_old_row;
    assign o_cell_written    = r_o_wr;
    assign o_cell_address    = r_o_addr;
    assign o_cell_value      = r_o_val;
    assign o_scrolled        = r_o_scroll;

endmodule

>>> rtl/core/text_console_cursor_engine.sv
`timescale 1ns / 1ps
// Text console cursor engine, top level: 80x25 cell screen store with a cursor.
// Depends on tcce_pkg, tcce_front, tcce_queue and tcce_back.
//
// Usage:
//   Requests come in on i_in_valid / o_in_stall: put a character, clear the
//   screen or set the cursor. Each request gives exactly one result on
//   o_out_valid / i_out_stall, in request order.
//   When the back end is free, an accepted request passes through the command
//   queue and then the result register before its result is presented.
//   Putting characters, moving the cursor and unused codes sustain one
//   request per cycle while no scroll runs and the receiver does not stall.
//   A scroll copies the store one cell per cycle through its single read and
//   write port; a clear writes blanks one cell per cycle.
//   Results of those requests come out right away; following requests wait.
//   After reset a clearing pass fills the store with blanks; o_in_stall stays
//   high until it ends. The cursor resets to home.
//   When the receiver stalls, the result holds; a two-entry queue keeps
//   taking requests until it fills, then o_in_stall rises.
module text_console_cursor_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcce_pkg::FUNC_W-1:0]   i_func,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_back_color,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_fore_color,
    input  logic [tcce_pkg::COL_W-1:0]    i_new_col,
    input  logic [tcce_pkg::ROW_W-1:0]    i_new_row,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcce_pkg::LOC_W-1:0]    o_cursor_location,
    output logic [tcce_pkg::COL_W-1:0]    o_old_col,
    output logic [tcce_pkg::ROW_W-1:0]    o_old_row,
    output logic                          o_cell_written,
    output logic [tcce_pkg::LOC_W-1:0]    o_cell_address,
    output logic [tcce_pkg::CELL_W-1:0]   o_cell_value,
    output logic                          o_scrolled
);
    import tcce_pkg::*;

    logic        push;
    t_cmd_entry  push_entry;
    logic        q_full;
    logic        q_valid;
    t_cmd_entry  q_entry;
    logic        q_pop;
    logic        init_busy;

    // Request classification.
    tcce_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_back_color (i_back_color),
        .i_fore_color (i_fore_color),
        .i_new_col    (i_new_col),
        .i_new_row    (i_new_row),
        .i_q_full     (q_full),
        .i_init_busy  (init_busy),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Command queue.
    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Command execution and screen store.
    tcce_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_entry         (q_entry),
        .o_q_pop           (q_pop),
        .o_init_busy       (init_busy),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cursor_location (o_cursor_location),
        .o_old_col         (o_old_col),
        .o_old_row         (o_old_row),
        .o_cell_written    (o_cell_written),
        .o_cell_address    (o_cell_address),
        .o_cell_value      (o_cell_value),
        .o_scrolled        (o_scrolled)
    );

endmodule

>>> rtl/core/tcce_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the text console cursor engine, bound to the top level.
// Depends on tcce_pkg for the screen geometry.
module tcce_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [tcce_pkg::LOC_W-1:0]    o_cursor_location,
    input  logic                          o_cell_written,
    input  logic [tcce_pkg::LOC_W-1:0]    o_cell_address,
    input  logic [tcce_pkg::CELL_W-1:0]   o_cell_value,
    input  logic                          o_scrolled
);
    import tcce_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_location)
            && $stable(o_cell_address) && $stable(o_cell_value) && $stable(o_scrolled))
        else $error("result changed while stalled");

    // The cursor never leaves the screen.
    a_loc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_location < LOC_W'(CELLS))
        else $error("cursor location beyond the screen");

    // Without a cell write the write fields are zero.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_cell_written |-> o_cell_address == '0 && o_cell_value == '0)
        else $error("write fields set without a cell write");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_location == SCROLL_END)
        else $error("scroll left the cursor off the bottom row start");

    // Only printable codes reach the store.
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_written |-> !o_cell_value[7] && o_cell_value[6:5] != 2'b00)
        else $error("non-printable code written to a cell");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_cursor_location (o_cursor_location),
    .o_cell_written    (o_cell_written),
    .o_cell_address    (o_cell_address),
    .o_cell_value      (o_cell_value),
    .o_scrolled        (o_scrolled)
);

>>> test/tcce_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the text console cursor engine: predicts each result from the cursor
// state and compares it with what the block delivers. Depends on tcce_pkg only.
module tcce_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [tcce_pkg::FUNC_W-1:0]   i_func,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_back_color,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_fore_color,
    input  logic [tcce_pkg::COL_W-1:0]    i_new_col,
    input  logic [tcce_pkg::ROW_W-1:0]    i_new_row,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [tcce_pkg::LOC_W-1:0]    i_cursor_location,
    input  logic [tcce_pkg::COL_W-1:0]    i_old_col,
    input  logic [tcce_pkg::ROW_W-1:0]    i_old_row,
    input  logic                          i_cell_written,
    input  logic [tcce_pkg::LOC_W-1:0]    i_cell_address,
    input  logic [tcce_pkg::CELL_W-1:0]   i_cell_value,
    input  logic                          i_scrolled,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_scroll_count,
    output int                            o_write_count
);
    import tcce_pkg::*;

    // One predicted result of a request.
    typedef struct {
        logic [LOC_W-1:0]   cursor_location;
        logic [COL_W-1:0]   old_col;
        logic [ROW_W-1:0]   old_row;
        logic               cell_written;
        logic [LOC_W-1:0]   cell_address;
        logic [CELL_W-1:0]  cell_value;
        logic               scrolled;
    } t_cursor_result;

    // The screen contents never reach the result port, so only the cursor is tracked.
    logic [COL_W-1:0] cursor_col = '0;
    logic [ROW_W-1:0] cursor_row = '0;

    t_cursor_result pending_results[$];

    int fail_total   = 0;
    int result_total = 0;
    int scroll_total = 0;
    int write_total  = 0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_scroll_count = 0;
        o_write_count  = 0;
    end

    // Apply one request to the cursor and work out the result it produces.
    function automatic t_cursor_result predict_cursor_step(
        input logic [FUNC_W-1:0]  func,
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] back,
        input logic [COLOR_W-1:0] fore,
        input logic [COL_W-1:0]   ncol,
        input logic [ROW_W-1:0]   nrow
    );
        t_cursor_result r;
        int col;
        int row;
        logic [ATTR_W-1:0] attr;
        r = '{default: '0};
        col = int'(cursor_col);
        row = int'(cursor_row);
        attr = {back, fore};
        case (func)
            FUNC_PUT: begin
                if (ch == CH_BS) begin
                    // Backspace only acts away from the left edge.
                    if (col != 0) begin
                        col--;
                        r.cell_written = 1'b1;
                        r.cell_address = LOC_W'(row * COLUMNS + col);
                        r.cell_value   = {attr, CH_SPACE};
                    end
                end else if (ch == CH_TAB) begin
                    col = col + TAB_STOP - (col % TAB_STOP);
                end else if (ch == CH_CR) begin
                    col = 0;
                end else if (ch == CH_LF) begin
                    col = 0;
                    row++;
                end else if (ch >= CH_SPACE && ch <= CH_LAST_DRAW) begin
                    r.cell_written = 1'b1;
                    r.cell_address = LOC_W'(row * COLUMNS + col);
                    r.cell_value   = {attr, ch};
                    col++;
                end
                // Wrap past the last column, then scroll past the last row.
                if (col >= COLUMNS) begin
                    col = 0;
                    row++;
                end
                if (row >= ROWS) begin
                    row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                col = 0;
                row = 0;
            end
            FUNC_SET: begin
                r.old_col = cursor_col;
                r.old_row = cursor_row;
                col = (int'(ncol) < COLUMNS) ? int'(ncol) : COLUMNS - 1;
                row = (int'(nrow) < ROWS) ? int'(nrow) : ROWS - 1;
            end
            default: begin
            end
        endcase
        cursor_col = COL_W'(col);
        cursor_row = ROW_W'(row);
        r.cursor_location = LOC_W'(row * COLUMNS + col);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_total++;
            $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Watch both channels; results are matched before the new request is predicted.
    always @(posedge i_clk) begin
        t_cursor_result want;
        if (!i_rst_n) begin
            cursor_col = '0;
            cursor_row = '0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    fail_total++;
                    $display("[%0t] result with no request pending: expected none, actual location 0x%0h",
                             $time, i_cursor_location);
                end else begin
                    want = pending_results.pop_front();
                    result_total++;
                    check_field("cursor_location", 32'(want.cursor_location),
                                32'(i_cursor_location));
                    check_field("old_col", 32'(want.old_col), 32'(i_old_col));
                    check_field("old_row", 32'(want.old_row), 32'(i_old_row));
                    check_field("cell_written", 32'(want.cell_written), 32'(i_cell_written));
                    check_field("cell_address", 32'(want.cell_address), 32'(i_cell_address));
                    check_field("cell_value", 32'(want.cell_value), 32'(i_cell_value));
                    check_field("scrolled", 32'(want.scrolled), 32'(i_scrolled));
                    if (want.scrolled) scroll_total++;
                    if (want.cell_written) write_total++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(predict_cursor_step(i_func, i_char_code, i_back_color,
                                                              i_fore_color, i_new_col, i_new_row));
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= pending_results.size();
        o_result_count <= result_total;
        o_scroll_count <= scroll_total;
        o_write_count  <= write_total;
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Top of the text console cursor engine testbench: clock, reset, request stimulus,
// random result stalls, watchdog and verdict. Depends on tcce_pkg and tcce_result_checker.
module tb_top;
    import tcce_pkg::*;

    // The command code the block leaves unused.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int QUIET_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [FUNC_W-1:0]   req_func  = FUNC_PUT;
    logic [CHAR_W-1:0]   req_char  = '0;
    logic [COLOR_W-1:0]  req_back  = '0;
    logic [COLOR_W-1:0]  req_fore  = '0;
    logic [COL_W-1:0]    req_col   = '0;
    logic [ROW_W-1:0]    req_row   = '0;

    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [LOC_W-1:0]    res_location;
    logic [COL_W-1:0]    res_old_col;
    logic [ROW_W-1:0]    res_old_row;
    logic                res_written;
    logic [LOC_W-1:0]    res_address;
    logic [CELL_W-1:0]   res_value;
    logic                res_scrolled;

    int fail_count;
    int pending;
    int result_count;
    int scroll_count;
    int write_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    text_console_cursor_engine dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .o_in_stall        (req_stall),
        .i_func            (req_func),
        .i_char_code       (req_char),
        .i_back_color      (req_back),
        .i_fore_color      (req_fore),
        .i_new_col         (req_col),
        .i_new_row         (req_row),
        .o_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .o_cursor_location (res_location),
        .o_old_col         (res_old_col),
        .o_old_row         (res_old_row),
        .o_cell_written    (res_written),
        .o_cell_address    (res_address),
        .o_cell_value      (res_value),
        .o_scrolled        (res_scrolled)
    );

    tcce_result_checker u_result_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .i_in_stall        (req_stall),
        .i_func            (req_func),
        .i_char_code       (req_char),
        .i_back_color      (req_back),
        .i_fore_color      (req_fore),
        .i_new_col         (req_col),
        .i_new_row         (req_row),
        .i_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .i_cursor_location (res_location),
        .i_old_col         (res_old_col),
        .i_old_row         (res_old_row),
        .i_cell_written    (res_written),
        .i_cell_address    (res_address),
        .i_cell_value      (res_value),
        .i_scrolled        (res_scrolled),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_result_count    (result_count),
        .o_scroll_count    (scroll_count),
        .o_write_count     (write_count)
    );

    // The result side stalls at random, at the rate of the current phase.
    always @(posedge clk) begin
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no request or result moved for %0d cycles",
                     $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request after random idle cycles and hold it until it is taken.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                                input logic [COLOR_W-1:0] back, input logic [COLOR_W-1:0] fore,
                                input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= func;
        req_char  <= ch;
        req_back  <= back;
        req_fore  <= fore;
        req_col   <= col;
        req_row   <= row;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] back,
                            input logic [COLOR_W-1:0] fore);
        send_request(FUNC_PUT, ch, back, fore, COL_W'($urandom), ROW_W'($urandom));
    endtask

    task automatic move_cursor(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        send_request(FUNC_SET, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     col, row);
    endtask

    task automatic send_command(input logic [FUNC_W-1:0] func);
        send_request(func, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     COL_W'($urandom), ROW_W'($urandom));
    endtask

    // Random mix of typing, cursor moves, clears and unused codes.
    task automatic run_random(input int target);
        int counted;
        int pick;
        int kind;
        logic [CHAR_W-1:0] ch;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_command(FUNC_CLEAR);
            end else if (pick < 5) begin
                send_command(FUNC_UNUSED);
            end else if (pick < 20) begin
                // Mostly in range, sometimes anywhere the fields reach.
                move_cursor(($urandom_range(0, 3) == 0) ? COL_W'($urandom)
                                                        : COL_W'($urandom_range(0, COLUMNS - 1)),
                            ($urandom_range(0, 3) == 0) ? ROW_W'($urandom)
                                                        : ROW_W'($urandom_range(0, ROWS - 1)));
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 55)      ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST_DRAW));
                else if (kind < 63) ch = CH_LF;
                else if (kind < 68) ch = CH_CR;
                else if (kind < 76) ch = CH_TAB;
                else if (kind < 86) ch = CH_BS;
                else if (kind < 93) ch = CHAR_W'($urandom_range(0, 31));
                else                ch = CHAR_W'($urandom_range(128, 255));
                put_char(ch, COLOR_W'($urandom), COLOR_W'($urandom));
            end
            counted++;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: drawable and ignored codes, editing codes, wrap and scroll.
        put_char(8'h41, 4'hF, 4'hF);
        put_char(CH_SPACE, 4'h0, 4'h0);
        put_char(CH_LAST_DRAW, 4'h3, 4'hC);
        put_char(8'h80, 4'h1, 4'h2);
        put_char(8'hFF, 4'h1, 4'h2);
        put_char(8'h00, 4'h1, 4'h2);
        put_char(8'h1F, 4'h1, 4'h2);
        put_char(CH_BS, 4'h6, 4'h9);
        put_char(CH_CR, 4'h0, 4'h0);
        put_char(CH_BS, 4'h6, 4'h9);
        put_char(CH_TAB, 4'h0, 4'h0);
        put_char(CH_TAB, 4'h0, 4'h0);
        move_cursor(COL_LAST, 5'd0);
        put_char(8'h78, 4'h2, 4'h7);
        put_char(CH_LF, 4'h0, 4'h0);
        // Out-of-range position saturates to the bottom right corner.
        move_cursor(7'h7F, 5'h1F);
        put_char(8'h7A, 4'hE, 4'h1);
        put_char(CH_LF, 4'h0, 4'h0);
        move_cursor(7'd72, ROW_LAST);
        put_char(CH_TAB, 4'h0, 4'h0);
        move_cursor(COL_LIMIT, ROW_LIMIT);
        put_char(CH_BS, 4'hA, 4'h5);
        send_command(FUNC_UNUSED);
        send_command(FUNC_CLEAR);
        put_char(8'h71, 4'h5, 4'hA);

        // Random phases with different idling on each side.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            run_random(ITEMS_PER_PHASE);
        end
        req_valid <= 1'b0;

        // Let the checker count the last request before waiting for its result.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over four idling phases: %0d cell writes, %0d scrolls.",
                 result_count, write_count, scroll_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
